// File: rtl/core/sfdd_pkg.sv
// Shared types and constants for the sensor frame decrypt/decode block.
// No dependencies; imported by every module under rtl/core.
`default_nettype none

package sfdd_pkg;

    localparam int TABLE_DEPTH = 256;
    localparam int CODE_W      = 8;
    localparam int VALUE_W     = 16;
    localparam int KEY_W       = 64;
    localparam int APB_ADDR_W  = 5;
    localparam int APB_DATA_W  = 64;

    localparam logic [7:0] END_MARK = 8'h0d;
    // nibble-swapped "Htemp99e", byte i in bits 8i+7..8i
    localparam logic [KEY_W-1:0] NIB_TEXT = 64'h5693_9307_d656_4784;

    localparam logic [KEY_W-1:0]  KEY_RESET    = '0;
    localparam logic [CODE_W-1:0] FIRST_RESET  = 8'd66;
    localparam logic [CODE_W-1:0] SECOND_RESET = 8'd80;
    localparam logic [1:0]        COUNT_RESET  = 2'd2;

    localparam logic OP_PROCESS = 1'b0;
    localparam logic OP_READ    = 1'b1;

    typedef enum logic [1:0] {
        REG_KEY,
        REG_FIRST,
        REG_SECOND,
        REG_COUNT
    } reg_idx_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_EVAL,
        ST_CLR2,
        ST_PUSH
    } state_t;

    typedef struct packed {
        logic               flag;
        logic [VALUE_W-1:0] value;
    } entry_t;

    typedef struct packed {
        logic [KEY_W-1:0]  key;
        logic [CODE_W-1:0] first;
        logic [CODE_W-1:0] second;
        logic [1:0]        count;
    } cfg_t;

    typedef struct packed {
        logic               ok;
        logic [CODE_W-1:0]  code;
        logic [VALUE_W-1:0] value;
    } dec_t;

    typedef struct packed {
        logic              rd_en;
        logic [CODE_W-1:0] rd_addr_a;
        logic [CODE_W-1:0] rd_addr_b;
        logic              wr_en;
        logic [CODE_W-1:0] wr_addr;
        entry_t            wr_data;
    } mem_req_t;

    typedef struct packed {
        entry_t a;
        entry_t b;
    } mem_rsp_t;

    typedef struct packed {
        logic               frame_ok;
        logic [CODE_W-1:0]  item_code;
        logic [VALUE_W-1:0] item_value;
        logic               entry_received;
        logic               round_done;
        logic [VALUE_W-1:0] first_value;
        logic [VALUE_W-1:0] second_value;
    } result_t;

endpackage

`default_nettype wire

// File: rtl/core/sfdd_decrypt.sv
// Frame decrypt: byte swaps, key XOR, 3-bit rotate, text subtract, end-mark check.
// Depends on sfdd_pkg. Purely combinational.
`default_nettype none

module sfdd_decrypt (
    input  wire logic [sfdd_pkg::KEY_W-1:0] frame_bytes,
    input  wire logic [sfdd_pkg::KEY_W-1:0] frame_key,
    output sfdd_pkg::dec_t                  dec
);
    import sfdd_pkg::*;

    logic [7:0] raw   [8];
    logic [7:0] swp   [8];
    logic [7:0] xr    [8];
    logic [7:0] rot   [8];
    logic [7:0] plain [8];
    logic [7:0] fin   [8];

    always_comb
    begin
        for (int i = 0; i < 8; i++)
        begin
            raw[i] = frame_bytes[8*i +: 8];
        end
        swp[0] = raw[2];
        swp[2] = raw[0];
        swp[1] = raw[4];
        swp[4] = raw[1];
        swp[3] = raw[7];
        swp[7] = raw[3];
        swp[5] = raw[6];
        swp[6] = raw[5];
        for (int i = 0; i < 8; i++)
        begin
            xr[i] = swp[i] ^ frame_key[8*i +: 8];
        end
        // byte 0 is the top of the chain; it takes its high bits from byte 7
        rot[0] = {xr[7][2:0], xr[0][7:3]};
        for (int i = 1; i < 8; i++)
        begin
            rot[i] = {xr[i-1][2:0], xr[i][7:3]};
        end
        for (int i = 0; i < 8; i++)
        begin
            plain[i] = rot[i] - NIB_TEXT[8*i +: 8];
            fin[i]   = (raw[4] != END_MARK) ? plain[i] : raw[i];
        end
        dec.ok    = (fin[4] == END_MARK);
        dec.code  = fin[0];
        dec.value = {fin[1], fin[2]};
    end

endmodule

`default_nettype wire

// File: rtl/core/sfdd_store.sv
// Entry store: 256 x {received flag, value} RAM, two registered read ports,
// one write port, and per-entry written bits that make untouched entries read zero.
// Depends on sfdd_pkg.
`default_nettype none

module sfdd_store (
    input  wire logic                clk,
    input  wire logic                rst_n,
    input  wire sfdd_pkg::mem_req_t  req,
    output sfdd_pkg::mem_rsp_t       rsp
);
    import sfdd_pkg::*;

    entry_t                 mem [TABLE_DEPTH];
    logic [TABLE_DEPTH-1:0] written_reg;
    entry_t                 rd_a_reg;
    entry_t                 rd_b_reg;
    logic                   vld_a_reg;
    logic                   vld_b_reg;

    always_ff @(posedge clk)
    begin
        if (req.wr_en)
        begin
            mem[req.wr_addr] <= req.wr_data;
        end
        if (req.rd_en)
        begin
            rd_a_reg <= mem[req.rd_addr_a];
            rd_b_reg <= mem[req.rd_addr_b];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            written_reg <= '0;
            vld_a_reg   <= 1'b0;
            vld_b_reg   <= 1'b0;
        end
        else
        begin
            if (req.wr_en)
            begin
                written_reg[req.wr_addr] <= 1'b1;
            end
            if (req.rd_en)
            begin
                vld_a_reg <= written_reg[req.rd_addr_a];
                vld_b_reg <= written_reg[req.rd_addr_b];
            end
        end
    end

    assign rsp.a.flag  = vld_a_reg & rd_a_reg.flag;
    assign rsp.a.value = vld_a_reg ? rd_a_reg.value : '0;
    assign rsp.b.flag  = vld_b_reg & rd_b_reg.flag;
    assign rsp.b.value = vld_b_reg ? rd_b_reg.value : '0;

endmodule

`default_nettype wire

// File: rtl/core/sfdd_ctrl.sv
// Item sequencer: stores the decoded frame, runs the round check with forwarding,
// clears flags through the store's write port, and holds the output register.
// Depends on sfdd_pkg; drives sfdd_store.
`default_nettype none

module sfdd_ctrl (
    input  wire logic                        clk,
    input  wire logic                        rst_n,
    input  wire logic                        in_valid,
    output logic                             in_stall,
    input  wire logic                        operation,
    input  wire logic [sfdd_pkg::CODE_W-1:0] read_index,
    input  wire sfdd_pkg::dec_t              dec,
    input  wire sfdd_pkg::cfg_t              cfg,
    output sfdd_pkg::mem_req_t               mem_req,
    input  wire sfdd_pkg::mem_rsp_t          mem_rsp,
    output logic                             out_valid,
    input  wire logic                        out_stall,
    output sfdd_pkg::result_t                result
);
    import sfdd_pkg::*;

    state_t              state_reg;
    state_t              state_next;
    logic                op_reg;
    logic                ok_reg;
    logic [CODE_W-1:0]   code_reg;
    logic [VALUE_W-1:0]  val_reg;
    logic [CODE_W-1:0]   idx_reg;
    result_t             res_reg;
    result_t             res_next;
    result_t             out_res_reg;
    logic                out_valid_reg;

    logic                accept;
    logic                push;
    logic [1:0]          count_eff;
    logic                need1;
    logic                need2;
    logic                hit_a;
    logic                hit_b;
    entry_t              ent_a;
    entry_t              ent_b;
    logic                done;

    assign accept    = in_valid && (state_reg == ST_IDLE);
    assign in_stall  = (state_reg != ST_IDLE);
    assign count_eff = (cfg.count == 2'd3) ? 2'd2 : cfg.count;
    assign need1     = (count_eff != 2'd0);
    assign need2     = (count_eff == 2'd2);

    // forward the entry written on accept; the RAM read saw the old contents
    assign hit_a = (op_reg == OP_PROCESS) && ok_reg && (code_reg == cfg.first);
    assign hit_b = (op_reg == OP_PROCESS) && ok_reg && (code_reg == cfg.second);
    assign ent_a = hit_a ? entry_t'{flag: 1'b1, value: val_reg} : mem_rsp.a;
    assign ent_b = hit_b ? entry_t'{flag: 1'b1, value: val_reg} : mem_rsp.b;
    assign done  = (!need1 || ent_a.flag) && (!need2 || ent_b.flag);

    always_comb
    begin
        state_next = state_reg;
        mem_req    = '0;
        res_next   = res_reg;
        push       = 1'b0;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    mem_req.rd_en     = 1'b1;
                    mem_req.rd_addr_a = (operation == OP_READ) ? read_index : cfg.first;
                    mem_req.rd_addr_b = cfg.second;
                    if ((operation == OP_PROCESS) && dec.ok)
                    begin
                        mem_req.wr_en   = 1'b1;
                        mem_req.wr_addr = dec.code;
                        mem_req.wr_data = '{flag: 1'b1, value: dec.value};
                    end
                    state_next = ST_EVAL;
                end
            end
            ST_EVAL:
            begin
                res_next = '0;
                if (op_reg == OP_READ)
                begin
                    res_next.item_code      = idx_reg;
                    res_next.item_value     = ent_a.value;
                    res_next.entry_received = ent_a.flag;
                    state_next              = ST_PUSH;
                end
                else
                begin
                    res_next.frame_ok = ok_reg;
                    if (ok_reg)
                    begin
                        res_next.item_code  = code_reg;
                        res_next.item_value = val_reg;
                    end
                    if (done)
                    begin
                        res_next.round_done   = 1'b1;
                        res_next.first_value  = ent_a.value;
                        res_next.second_value = ent_b.value;
                    end
                    // clear the first flag now, the second in the next cycle
                    if (done && need1)
                    begin
                        mem_req.wr_en   = 1'b1;
                        mem_req.wr_addr = cfg.first;
                        mem_req.wr_data = '{flag: 1'b0, value: ent_a.value};
                    end
                    state_next = (done && need2) ? ST_CLR2 : ST_PUSH;
                end
            end
            ST_CLR2:
            begin
                mem_req.wr_en   = 1'b1;
                mem_req.wr_addr = cfg.second;
                mem_req.wr_data = '{flag: 1'b0, value: res_reg.second_value};
                state_next      = ST_PUSH;
            end
            ST_PUSH:
            begin
                // hold until the output register is free
                if (!out_valid_reg || !out_stall)
                begin
                    push       = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if (push)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (!out_stall)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            op_reg   <= operation;
            ok_reg   <= dec.ok;
            code_reg <= dec.code;
            val_reg  <= dec.value;
            idx_reg  <= read_index;
        end
        res_reg <= res_next;
        if (push)
        begin
            out_res_reg <= res_reg;
        end
    end

    assign out_valid = out_valid_reg;
    assign result    = out_res_reg;

endmodule

`default_nettype wire

// File: rtl/core/sensor_frame_decrypt_decode_top.sv
// Top level of the sensor frame decrypt/decode block: APB register file and wiring.
// Depends on sfdd_pkg, sfdd_decrypt, sfdd_store and sfdd_ctrl.
//
//   Channel  Direction  Handshake           Payload
//   -------  ---------  ------------------  ----------------------------------------------
//   input    in         in_valid/in_stall   operation, frame_bytes, read_index
//   output   out        out_valid/out_stall frame_ok, item_code, item_value, entry_received,
//                                           round_done, first_value, second_value
//   config   in/out     APB psel/penable    paddr, pwdata, prdata, pready
//
// A read, or a frame whose round is not done or needs one flag cleared, goes through
// the idle, eval and push states; a round done with two flags cleared adds the clear
// state after eval, set by the single write port of the entry RAM and its registered
// read. The push state repeats while a previous result is still held on the output.
// Reset is asynchronous; per-entry written bits clear at once, so no clearing pass.
// in_stall is high from the cycle after an item is taken until its result is loaded.
`default_nettype none

module sensor_frame_decrypt_decode_top (
    input  wire logic                            clk,
    input  wire logic                            rst_n,
    input  wire logic                            psel,
    input  wire logic                            penable,
    input  wire logic                            pwrite,
    input  wire logic [sfdd_pkg::APB_ADDR_W-1:0] paddr,
    input  wire logic [sfdd_pkg::APB_DATA_W-1:0] pwdata,
    output logic      [sfdd_pkg::APB_DATA_W-1:0] prdata,
    output logic                                 pready,
    input  wire logic                            in_valid,
    output logic                                 in_stall,
    input  wire logic                            operation,
    input  wire logic [sfdd_pkg::KEY_W-1:0]      frame_bytes,
    input  wire logic [sfdd_pkg::CODE_W-1:0]     read_index,
    output logic                                 out_valid,
    input  wire logic                            out_stall,
    output logic                                 frame_ok,
    output logic      [sfdd_pkg::CODE_W-1:0]     item_code,
    output logic      [sfdd_pkg::VALUE_W-1:0]    item_value,
    output logic                                 entry_received,
    output logic                                 round_done,
    output logic      [sfdd_pkg::VALUE_W-1:0]    first_value,
    output logic      [sfdd_pkg::VALUE_W-1:0]    second_value
);
    import sfdd_pkg::*;

    logic [KEY_W-1:0]  key_reg;
    logic [CODE_W-1:0] first_reg;
    logic [CODE_W-1:0] second_reg;
    logic [1:0]        count_reg;
    logic              cfg_write;
    reg_idx_t          reg_sel;

    cfg_t              cfg;
    dec_t              dec;
    mem_req_t          mem_req;
    mem_rsp_t          mem_rsp;
    result_t           result;

    assign pready    = 1'b1;
    assign cfg_write = psel && penable && pwrite && pready;
    assign reg_sel   = reg_idx_t'(paddr[4:3]);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            key_reg    <= KEY_RESET;
            first_reg  <= FIRST_RESET;
            second_reg <= SECOND_RESET;
            count_reg  <= COUNT_RESET;
        end
        else if (cfg_write)
        begin
            unique case (reg_sel)
                REG_KEY:    key_reg    <= pwdata;
                REG_FIRST:  first_reg  <= pwdata[CODE_W-1:0];
                REG_SECOND: second_reg <= pwdata[CODE_W-1:0];
                REG_COUNT:  count_reg  <= pwdata[1:0];
                default:    key_reg    <= key_reg;
            endcase
        end
    end

    always_comb
    begin
        unique case (reg_sel)
            REG_KEY:    prdata = key_reg;
            REG_FIRST:  prdata = APB_DATA_W'(first_reg);
            REG_SECOND: prdata = APB_DATA_W'(second_reg);
            REG_COUNT:  prdata = APB_DATA_W'(count_reg);
            default:    prdata = '0;
        endcase
    end

    assign cfg.key    = key_reg;
    assign cfg.first  = first_reg;
    assign cfg.second = second_reg;
    assign cfg.count  = count_reg;

    sfdd_decrypt u_decrypt (
        .frame_bytes (frame_bytes),
        .frame_key   (key_reg),
        .dec         (dec)
    );

    sfdd_store u_store (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (mem_req),
        .rsp   (mem_rsp)
    );

    sfdd_ctrl u_ctrl (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (in_valid),
        .in_stall   (in_stall),
        .operation  (operation),
        .read_index (read_index),
        .dec        (dec),
        .cfg        (cfg),
        .mem_req    (mem_req),
        .mem_rsp    (mem_rsp),
        .out_valid  (out_valid),
        .out_stall  (out_stall),
        .result     (result)
    );

    assign frame_ok       = result.frame_ok;
    assign item_code      = result.item_code;
    assign item_value     = result.item_value;
    assign entry_received = result.entry_received;
    assign round_done     = result.round_done;
    assign first_value    = result.first_value;
    assign second_value   = result.second_value;

    // the sequencer goes busy right after taking an item
    a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && !in_stall |=> in_stall)
        else $error("input not stalled after an item was taken");

    // a new result is only loaded from the busy sequencer
    a_result_from_busy: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid) |-> $past(in_stall))
        else $error("result appeared without an item in progress");

    // a round report only comes from a processed frame
    a_round_not_read: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && round_done |-> !entry_received)
        else $error("round report carries a read flag");

    a_values_need_round: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && ((first_value != '0) || (second_value != '0)) |-> round_done)
        else $error("required values reported without a finished round");

endmodule

`default_nettype wire

// File: dv/sensor_frame_decrypt_decode_top_test.sv
// Self-checking testbench for sensor_frame_decrypt_decode_top: directed and random frames,
// entry reads and register settings, checked against a frame decoder model in the scoreboard.
// Depends on sfdd_pkg and the RTL of sensor_frame_decrypt_decode_top.

module sensor_frame_decrypt_decode_top_test;
    import sfdd_pkg::*;

    localparam int CYCLE_LIMIT = 400000;
    localparam int PHASE_ITEMS = 180;
    localparam int SETTLE_CYCLES = 8;

    class frame_scoreboard;
        logic [VALUE_W-1:0] values[TABLE_DEPTH];
        bit                 flags[TABLE_DEPTH];
        logic [KEY_W-1:0]   key;
        logic [CODE_W-1:0]  first;
        logic [CODE_W-1:0]  second;
        logic [1:0]         count;
        result_t            expected_q[$];
        int                 errors;

        function new();
            foreach (values[i])
            begin
                values[i] = '0;
                flags[i] = 1'b0;
            end
            key = KEY_RESET;
            first = FIRST_RESET;
            second = SECOND_RESET;
            count = COUNT_RESET;
            errors = 0;
        endfunction

        function void write_reg(reg_idx_t idx, logic [63:0] data);
            case (idx)
                REG_KEY:    key = data;
                REG_FIRST:  first = data[7:0];
                REG_SECOND: second = data[7:0];
                REG_COUNT:  count = data[1:0];
                default:    ;
            endcase
        endfunction

        // swap, xor with key, rotate the byte chain right by 3, subtract the text
        function logic [63:0] decrypt_frame(logic [63:0] raw);
            logic [7:0]  b[8];
            logic [7:0]  s[8];
            logic [63:0] plain;
            for (int i = 0; i < 8; i++)
                b[i] = raw[8*i +: 8];
            s[0] = b[2]; s[2] = b[0];
            s[1] = b[4]; s[4] = b[1];
            s[3] = b[7]; s[7] = b[3];
            s[5] = b[6]; s[6] = b[5];
            for (int i = 0; i < 8; i++)
                s[i] = s[i] ^ key[8*i +: 8];
            for (int i = 0; i < 8; i++)
                plain[8*i +: 8] = {s[(i + 7) % 8][2:0], s[i][7:3]} - NIB_TEXT[8*i +: 8];
            return plain;
        endfunction

        function void note_input(logic op, logic [63:0] raw, logic [7:0] idx);
            result_t           r;
            logic [63:0]       plain;
            logic [CODE_W-1:0] code;
            int                n;
            bit                done;
            r = '0;
            if (op == OP_READ)
            begin
                r.item_code = idx;
                r.item_value = values[idx];
                r.entry_received = flags[idx];
            end
            else
            begin
                plain = (raw[39:32] != END_MARK) ? decrypt_frame(raw) : raw;
                if (plain[39:32] == END_MARK)
                begin
                    code = plain[7:0];
                    values[code] = {plain[15:8], plain[23:16]};
                    flags[code] = 1'b1;
                    r.frame_ok = 1'b1;
                    r.item_code = code;
                    r.item_value = values[code];
                end
                n = (count > 2) ? 2 : count;
                done = 1'b1;
                if (n >= 1 && !flags[first])
                    done = 1'b0;
                if (n >= 2 && !flags[second])
                    done = 1'b0;
                if (done)
                begin
                    r.round_done = 1'b1;
                    r.first_value = values[first];
                    r.second_value = values[second];
                    if (n >= 1)
                        flags[first] = 1'b0;
                    if (n >= 2)
                        flags[second] = 1'b0;
                end
            end
            expected_q.push_back(r);
        endfunction

        function void compare_field(string name, logic [15:0] exp, logic [15:0] act);
            if (act !== exp)
            begin
                $display("%0t: %s mismatch, expected %h actual %h", $time, name, exp, act);
                errors++;
            end
        endfunction

        function void check_result(result_t got);
            result_t exp;
            if (expected_q.size() == 0)
            begin
                $display("%0t: unexpected result, actual %p", $time, got);
                errors++;
                return;
            end
            exp = expected_q.pop_front();
            compare_field("frame_ok", 16'(exp.frame_ok), 16'(got.frame_ok));
            compare_field("item_code", 16'(exp.item_code), 16'(got.item_code));
            compare_field("item_value", exp.item_value, got.item_value);
            compare_field("entry_received", 16'(exp.entry_received),
                          16'(got.entry_received));
            compare_field("round_done", 16'(exp.round_done), 16'(got.round_done));
            compare_field("first_value", exp.first_value, got.first_value);
            compare_field("second_value", exp.second_value, got.second_value);
        endfunction

        function int pending();
            return expected_q.size();
        endfunction
    endclass

    logic                  clk;
    logic                  rst_n;
    logic                  psel;
    logic                  penable;
    logic                  pwrite;
    logic [APB_ADDR_W-1:0] paddr;
    logic [APB_DATA_W-1:0] pwdata;
    logic [APB_DATA_W-1:0] prdata;
    logic                  pready;
    logic                  in_valid;
    logic                  in_stall;
    logic                  operation;
    logic [KEY_W-1:0]      frame_bytes;
    logic [CODE_W-1:0]     read_index;
    logic                  out_valid;
    logic                  out_stall;
    logic                  frame_ok;
    logic [CODE_W-1:0]     item_code;
    logic [VALUE_W-1:0]    item_value;
    logic                  entry_received;
    logic                  round_done;
    logic [VALUE_W-1:0]    first_value;
    logic [VALUE_W-1:0]    second_value;

    frame_scoreboard sb;
    bit              steady;
    int              cycles;

    sensor_frame_decrypt_decode_top u_top (
        .clk            (clk),
        .rst_n          (rst_n),
        .psel           (psel),
        .penable        (penable),
        .pwrite         (pwrite),
        .paddr          (paddr),
        .pwdata         (pwdata),
        .prdata         (prdata),
        .pready         (pready),
        .in_valid       (in_valid),
        .in_stall       (in_stall),
        .operation      (operation),
        .frame_bytes    (frame_bytes),
        .read_index     (read_index),
        .out_valid      (out_valid),
        .out_stall      (out_stall),
        .frame_ok       (frame_ok),
        .item_code      (item_code),
        .item_value     (item_value),
        .entry_received (entry_received),
        .round_done     (round_done),
        .first_value    (first_value),
        .second_value   (second_value)
    );

    initial
    begin
        clk = 1'b0;
        forever #6 clk = ~clk;
    end

    always @(posedge clk)
    begin
        cycles++;
        if (cycles > CYCLE_LIMIT)
        begin
            $display("FAILURE");
            $finish;
        end
    end

    always @(negedge clk)
        out_stall <= !steady && ($urandom_range(0, 99) < 31);

    always @(posedge clk)
    begin
        result_t got;
        if (rst_n && out_valid && !out_stall)
        begin
            got.frame_ok = frame_ok;
            got.item_code = item_code;
            got.item_value = item_value;
            got.entry_received = entry_received;
            got.round_done = round_done;
            got.first_value = first_value;
            got.second_value = second_value;
            sb.check_result(got);
        end
    end

    // inverse of the decrypt: add the text, rotate left by 3, xor, swap back
    function automatic logic [63:0] encrypt_frame(logic [63:0] plain, logic [63:0] key);
        logic [7:0]  r[8];
        logic [7:0]  s[8];
        logic [63:0] raw;
        for (int i = 0; i < 8; i++)
            r[i] = plain[8*i +: 8] + NIB_TEXT[8*i +: 8];
        for (int i = 0; i < 8; i++)
            s[i] = {r[i][4:0], r[(i + 1) % 8][7:5]} ^ key[8*i +: 8];
        raw[23:16] = s[0]; raw[7:0]   = s[2];
        raw[39:32] = s[1]; raw[15:8]  = s[4];
        raw[63:56] = s[3]; raw[31:24] = s[7];
        raw[55:48] = s[5]; raw[47:40] = s[6];
        return raw;
    endfunction

    function automatic logic [63:0] make_frame(logic [7:0] code, logic [15:0] value, bit plain);
        logic [63:0] p;
        p = {$urandom, $urandom};
        p[7:0] = code;
        p[15:8] = value[15:8];
        p[23:16] = value[7:0];
        p[39:32] = END_MARK;
        return plain ? p : encrypt_frame(p, sb.key);
    endfunction

    function automatic logic [7:0] pick_code();
        int r;
        r = $urandom_range(0, 9);
        if (r < 4)
            return sb.first;
        if (r < 7)
            return sb.second;
        return 8'($urandom_range(0, 255));
    endfunction

    // called at a falling edge; returns at the falling edge after the item is taken
    task automatic send_item(logic op, logic [63:0] raw, logic [7:0] idx);
        while (!steady && $urandom_range(0, 99) < 31)
        begin
            in_valid <= 1'b0;
            @(negedge clk);
        end
        in_valid <= 1'b1;
        operation <= op;
        frame_bytes <= raw;
        read_index <= idx;
        @(posedge clk);
        while (!(in_valid && !in_stall))
            @(posedge clk);
        sb.note_input(op, raw, idx);
        @(negedge clk);
    endtask

    task automatic send_random();
        int         pick;
        logic [7:0] code;
        pick = $urandom_range(0, 99);
        code = pick_code();
        if (pick < 15)
            send_item(OP_READ, {$urandom, $urandom}, code);
        else if (pick < 25)
            send_item(OP_PROCESS, {$urandom, $urandom}, 8'($urandom_range(0, 255)));
        else
            send_item(OP_PROCESS, make_frame(code, 16'($urandom_range(0, 65535)),
                                             $urandom_range(0, 3) == 0),
                      8'($urandom_range(0, 255)));
    endtask

    // hold off new items until every result is back
    task automatic drain();
        in_valid <= 1'b0;
        while (sb.pending() != 0)
            @(negedge clk);
    endtask

    task automatic apb_write(reg_idx_t idx, logic [63:0] data);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b1;
        paddr <= {idx, 3'b000};
        pwdata <= data;
        @(negedge clk);
        penable <= 1'b1;
        @(posedge clk);
        while (!pready)
            @(posedge clk);
        sb.write_reg(idx, data);
        @(negedge clk);
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
        // leave the bus idle before the next transfer
        @(negedge clk);
    endtask

    task automatic configure(logic [63:0] key, logic [7:0] first, logic [7:0] second,
                             logic [1:0] count);
        drain();
        repeat (SETTLE_CYCLES) @(negedge clk);
        apb_write(REG_KEY, key);
        apb_write(REG_FIRST, 64'(first));
        apb_write(REG_SECOND, 64'(second));
        apb_write(REG_COUNT, 64'(count));
    endtask

    initial
    begin
        logic [7:0] shared_code;
        sb = new();
        steady = 1'b0;
        cycles = 0;
        rst_n = 1'b0;
        psel = 1'b0;
        penable = 1'b0;
        pwrite = 1'b0;
        paddr = '0;
        pwdata = '0;
        in_valid = 1'b0;
        operation = OP_PROCESS;
        frame_bytes = '0;
        read_index = '0;
        out_stall = 1'b0;
        repeat (5) @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // reset settings: key zero, codes 66 and 80, both checked
        send_item(OP_PROCESS, '0, 8'h00);
        send_item(OP_PROCESS, '1, 8'hff);
        send_item(OP_PROCESS, make_frame(8'd66, 16'hffff, 1'b1), 8'h00);
        send_item(OP_READ, '1, 8'd66);
        send_item(OP_PROCESS, make_frame(8'd80, 16'h0000, 1'b1), 8'h00);
        send_item(OP_READ, '0, 8'd66);
        send_item(OP_READ, '0, 8'd0);
        send_item(OP_READ, '1, 8'd255);
        send_item(OP_PROCESS, make_frame(8'd255, 16'h1234, 1'b0), 8'h00);
        send_item(OP_PROCESS, make_frame(8'd0, 16'habcd, 1'b0), 8'h00);
        send_item(OP_READ, '0, 8'd255);

        // zero count: every frame closes a round, rejected ones too
        configure('1, 8'd0, 8'd255, 2'd0);
        send_item(OP_PROCESS, make_frame(8'd7, 16'h8001, 1'b0), 8'h00);
        send_item(OP_PROCESS, 64'h5555_5555_aaaa_aaaa, 8'h00);
        // count of 3 behaves as 2
        configure('1, 8'd0, 8'd255, 2'd3);
        send_item(OP_PROCESS, make_frame(8'd0, 16'h00ff, 1'b0), 8'h00);
        send_item(OP_READ, '0, 8'd0);
        send_item(OP_PROCESS, make_frame(8'd255, 16'hff00, 1'b1), 8'h00);
        // count of 1: only the first code clears
        configure({$urandom, $urandom}, 8'd0, 8'd255, 2'd1);
        send_item(OP_PROCESS, make_frame(8'd255, 16'h0f0f, 1'b0), 8'h00);
        send_item(OP_PROCESS, make_frame(8'd0, 16'hf0f0, 1'b0), 8'h00);
        send_item(OP_READ, '0, 8'd255);

        for (int phase = 0; phase < 6; phase++)
        begin
            shared_code = 8'($urandom_range(0, 255));
            case (phase)
                0: configure({$urandom, $urandom}, 8'd66, 8'd80, 2'd2);
                1: configure('0, 8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)),
                             2'd1);
                2: configure('1, 8'd0, 8'd255, 2'd3);
                3: configure({$urandom, $urandom}, shared_code, shared_code, 2'd2);
                4: configure({$urandom, $urandom}, 8'($urandom_range(0, 255)),
                             8'($urandom_range(0, 255)), 2'd0);
                default: configure({$urandom, $urandom}, 8'($urandom_range(0, 255)),
                                   8'($urandom_range(0, 255)), 2'd2);
            endcase
            steady = (phase == 5);
            for (int n = 0; n < PHASE_ITEMS; n++)
            begin
                if (n == PHASE_ITEMS / 2)
                    drain();
                send_random();
            end
        end

        drain();
        steady = 1'b0;
        repeat (SETTLE_CYCLES * 3) @(posedge clk);
        if (sb.errors == 0 && sb.pending() == 0)
            $display("SUCCESS");
        else
            $display("FAILURE");
        $finish;
    end

endmodule
